// ----- rtl/csr_graph_check_and_vertex_reorder_macros.svh -----
// assertion macros for the vertex reorder block
// needs clock and reset in the scope where a macro is used
`ifndef CSR_GRAPH_CHECK_AND_VERTEX_REORDER_MACROS_SVH
`define CSR_GRAPH_CHECK_AND_VERTEX_REORDER_MACROS_SVH

// same-cycle implication
`define CGVR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cgvr assertion failed");

// next-cycle implication
`define CGVR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cgvr assertion failed");

`endif

// ----- rtl/cgvr_pkg.sv -----
// shared types and constants for the vertex reorder block
// no dependencies
`default_nettype none
package cgvr_pkg;
   localparam int CMD_W    = 3;
   localparam int SLOT_W   = 13;
   localparam int VAL_W    = 13;
   localparam int WGT_W    = 32;
   localparam int STS_W    = 4;
   localparam int VC_W     = 11;
   localparam int VID_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;
   localparam int OFS_AW   = 12;
   localparam int EDGE_AW  = 13;

   localparam logic [SLOT_W-1:0] MAX_VERTICES = 13'd1024;
   localparam logic [SLOT_W-1:0] MAX_EDGES    = 13'd4096;

   // commands
   localparam logic [CMD_W-1:0] CMD_LOAD_OFS  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_EDGE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_ORD  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RUN       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_OFS  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ_EDGE = 3'd5;

   // status codes
   localparam logic [STS_W-1:0] STS_OK          = 4'd0;
   localparam logic [STS_W-1:0] STS_FIRST_OFS   = 4'd1;
   localparam logic [STS_W-1:0] STS_OFS_DEC     = 4'd2;
   localparam logic [STS_W-1:0] STS_LAST_OFS    = 4'd3;
   localparam logic [STS_W-1:0] STS_BAD_DST     = 4'd4;
   localparam logic [STS_W-1:0] STS_ORD_RANGE   = 4'd5;
   localparam logic [STS_W-1:0] STS_ORD_DUP     = 4'd6;
   localparam logic [STS_W-1:0] STS_SLOT_RANGE  = 4'd7;
   localparam logic [STS_W-1:0] STS_NO_WEIGHTS  = 4'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_COUNT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_PRESENT = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_WAIT,
      ST_OFS_RD, ST_OFS_CMP, ST_DST_RD, ST_DST_CMP,
      ST_CLR, ST_ORD_RD, ST_ORD_CHK, ST_ORD_SEEN,
      ST_RB_ORD_RD, ST_RB_ORD, ST_RB_BEG, ST_RB_END,
      ST_RB_EDGE, ST_RB_INV, ST_RB_WR
   } state_type;
endpackage
`default_nettype wire

// ----- rtl/cgvr_channels.sv -----
// valid/ready channel interfaces for request, response and register writes
// depends on cgvr_pkg
`default_nettype none
interface cgvr_req_if;
   logic                        valid;
   logic                        ready;
   logic [cgvr_pkg::CMD_W-1:0]  command;
   logic [cgvr_pkg::SLOT_W-1:0] slot;
   logic [cgvr_pkg::VAL_W-1:0]  item_value;
   logic [cgvr_pkg::WGT_W-1:0]  edge_weight;
   modport source (output valid, command, slot, item_value, edge_weight, input ready);
   modport sink (input valid, command, slot, item_value, edge_weight, output ready);
endinterface

interface cgvr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cgvr_pkg::STS_W-1:0] status;
   logic [cgvr_pkg::VAL_W-1:0] read_value;
   logic [cgvr_pkg::WGT_W-1:0] read_weight;
   modport source (output valid, status, read_value, read_weight, input ready);
   modport sink (input valid, status, read_value, read_weight, output ready);
endinterface

interface cgvr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [cgvr_pkg::CSR_IDX_W-1:0] reg_index;
   logic [cgvr_pkg::CSR_DAT_W-1:0] wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/csr_graph_check_and_vertex_reorder.sv -----
// loads, reads: one load transfer per cycle while no response waits; a read's data passes the
//   memory read register, then the response register; run: offset check, destination check,
//   seen-bit clearing pass over all 1024 entries, order check, rebuild, one read port per store;
//   one item is in flight at a time, ready is low until its response is taken
// reset: synchronous, active high; clears the sequencer, response valid, registers, bank
`default_nettype none
module csr_graph_check_and_vertex_reorder (
   input  wire logic  clock,
   input  wire logic  reset,
   cgvr_req_if.sink   req_ch,
   cgvr_rsp_if.source rsp_ch,
   cgvr_csr_if.sink   csr_ch
);
   localparam int OFS_DEPTH  = 2 ** cgvr_pkg::OFS_AW;
   localparam int EDGE_DEPTH = 2 ** cgvr_pkg::EDGE_AW;
   localparam int VTX_DEPTH  = 2 ** cgvr_pkg::VID_W;

   cgvr_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [cgvr_pkg::VC_W-1:0]   vc_ff;
   logic [cgvr_pkg::SLOT_W-1:0] ec_ff;
   logic                        wp_ff;
   logic                        bank_ff, bank_in;

   // sequencer registers
   logic [cgvr_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [cgvr_pkg::VAL_W-1:0]  prev_ff, prev_in;
   logic [cgvr_pkg::VID_W-1:0]  old_ff, old_in;
   logic [cgvr_pkg::VAL_W-1:0]  e_ff, e_in, end_ff, end_in, pos_ff, pos_in;
   logic [cgvr_pkg::WGT_W-1:0]  whold_ff, whold_in;
   logic                        rd_edge_ff, rd_edge_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cgvr_pkg::STS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [cgvr_pkg::VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [cgvr_pkg::WGT_W-1:0]  rsp_weight_ff, rsp_weight_in;

   // memories
   logic [cgvr_pkg::VAL_W-1:0]  ofs_mem [OFS_DEPTH];
   logic [cgvr_pkg::VAL_W-1:0]  dst_mem [EDGE_DEPTH];
   logic [cgvr_pkg::WGT_W-1:0]  wgt_mem [EDGE_DEPTH];
   logic [cgvr_pkg::VAL_W-1:0]  ord_mem [VTX_DEPTH];
   logic [cgvr_pkg::VID_W-1:0]  inv_mem [VTX_DEPTH];
   logic                        seen_mem [VTX_DEPTH];

   logic                         ofs_we, dst_we, ord_we, inv_we, seen_we;
   logic [cgvr_pkg::OFS_AW-1:0]  ofs_waddr, ofs_raddr;
   logic [cgvr_pkg::EDGE_AW-1:0] dst_waddr, dst_raddr;
   logic [cgvr_pkg::VID_W-1:0]   ord_waddr, ord_raddr, inv_waddr, inv_raddr;
   logic [cgvr_pkg::VID_W-1:0]   seen_waddr, seen_raddr;
   logic [cgvr_pkg::VAL_W-1:0]   ofs_wdata, dst_wdata, ord_wdata;
   logic [cgvr_pkg::WGT_W-1:0]   wgt_wdata;
   logic [cgvr_pkg::VID_W-1:0]   inv_wdata;
   logic                         seen_wdata;
   logic [cgvr_pkg::VAL_W-1:0]   ofs_rdata_ff, dst_rdata_ff, ord_rdata_ff;
   logic [cgvr_pkg::WGT_W-1:0]   wgt_rdata_ff;
   logic [cgvr_pkg::VID_W-1:0]   inv_rdata_ff;
   logic                         seen_rdata_ff;

   // handshake and shared conditions
   logic req_ready, req_fire;
   logic [cgvr_pkg::SLOT_W-1:0] vc_ext;
   logic run_bad, rd_ofs_bad, rd_edge_bad, idx_is_vc;
   logic ofs_fail_first, ofs_fail_dec, ofs_fail_last;
   logic dst_bad, ord_bad, edge_more;

   assign req_ready    = (state_ff == cgvr_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.read_value  = rsp_value_ff;
   assign rsp_ch.read_weight = rsp_weight_ff;

   assign vc_ext      = {2'b00, vc_ff};
   assign run_bad     = (vc_ext > cgvr_pkg::MAX_VERTICES) || (ec_ff > cgvr_pkg::MAX_EDGES);
   assign rd_ofs_bad  = (req_ch.slot > vc_ext) || (req_ch.slot > cgvr_pkg::MAX_VERTICES);
   assign rd_edge_bad = (req_ch.slot >= ec_ff) || (req_ch.slot >= cgvr_pkg::MAX_EDGES);
   assign idx_is_vc   = (idx_ff == vc_ext);
   assign ofs_fail_first = (idx_ff == '0) && (ofs_rdata_ff != '0);
   assign ofs_fail_dec   = (idx_ff != '0) && (ofs_rdata_ff < prev_ff);
   assign ofs_fail_last  = idx_is_vc && (ofs_rdata_ff != ec_ff);
   assign dst_bad   = dst_rdata_ff >= vc_ext;
   assign ord_bad   = ord_rdata_ff >= vc_ext;
   assign edge_more = (e_ff < end_ff) && (pos_ff < cgvr_pkg::MAX_EDGES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cgvr_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.command)
                  cgvr_pkg::CMD_RUN:
                     state_in = run_bad ? cgvr_pkg::ST_IDLE : cgvr_pkg::ST_OFS_RD;
                  cgvr_pkg::CMD_READ_OFS:
                     state_in = rd_ofs_bad ? cgvr_pkg::ST_IDLE : cgvr_pkg::ST_RD_WAIT;
                  cgvr_pkg::CMD_READ_EDGE:
                     state_in = rd_edge_bad ? cgvr_pkg::ST_IDLE : cgvr_pkg::ST_RD_WAIT;
                  default: state_in = cgvr_pkg::ST_IDLE;
               endcase
            end
         end
         cgvr_pkg::ST_RD_WAIT: state_in = cgvr_pkg::ST_IDLE;
         cgvr_pkg::ST_OFS_RD:  state_in = cgvr_pkg::ST_OFS_CMP;
         cgvr_pkg::ST_OFS_CMP: begin
            if (ofs_fail_first || ofs_fail_dec || ofs_fail_last) state_in = cgvr_pkg::ST_IDLE;
            else if (idx_is_vc) state_in = cgvr_pkg::ST_DST_RD;
            else state_in = cgvr_pkg::ST_OFS_RD;
         end
         cgvr_pkg::ST_DST_RD:
            state_in = (idx_ff == ec_ff) ? cgvr_pkg::ST_CLR : cgvr_pkg::ST_DST_CMP;
         cgvr_pkg::ST_DST_CMP:
            state_in = dst_bad ? cgvr_pkg::ST_IDLE : cgvr_pkg::ST_DST_RD;
         cgvr_pkg::ST_CLR:
            state_in = (idx_ff[cgvr_pkg::VID_W-1:0] == '1) ? cgvr_pkg::ST_ORD_RD
                                                          : cgvr_pkg::ST_CLR;
         cgvr_pkg::ST_ORD_RD:
            state_in = idx_is_vc ? cgvr_pkg::ST_RB_ORD_RD : cgvr_pkg::ST_ORD_CHK;
         cgvr_pkg::ST_ORD_CHK:
            state_in = ord_bad ? cgvr_pkg::ST_IDLE : cgvr_pkg::ST_ORD_SEEN;
         cgvr_pkg::ST_ORD_SEEN:
            state_in = seen_rdata_ff ? cgvr_pkg::ST_IDLE : cgvr_pkg::ST_ORD_RD;
         cgvr_pkg::ST_RB_ORD_RD:
            state_in = idx_is_vc ? cgvr_pkg::ST_IDLE : cgvr_pkg::ST_RB_ORD;
         cgvr_pkg::ST_RB_ORD: state_in = cgvr_pkg::ST_RB_BEG;
         cgvr_pkg::ST_RB_BEG: state_in = cgvr_pkg::ST_RB_END;
         cgvr_pkg::ST_RB_END: state_in = cgvr_pkg::ST_RB_EDGE;
         cgvr_pkg::ST_RB_EDGE:
            state_in = edge_more ? cgvr_pkg::ST_RB_INV : cgvr_pkg::ST_RB_ORD_RD;
         cgvr_pkg::ST_RB_INV: state_in = cgvr_pkg::ST_RB_WR;
         cgvr_pkg::ST_RB_WR:  state_in = cgvr_pkg::ST_RB_EDGE;
         default: state_in = cgvr_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      idx_in     = idx_ff;
      prev_in    = prev_ff;
      old_in     = old_ff;
      e_in       = e_ff;
      end_in     = end_ff;
      pos_in     = pos_ff;
      whold_in   = whold_ff;
      rd_edge_in = rd_edge_ff;
      bank_in    = bank_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_weight_in = rsp_weight_ff;

      ofs_we = 1'b0; dst_we = 1'b0; ord_we = 1'b0; inv_we = 1'b0; seen_we = 1'b0;
      ofs_waddr = {bank_ff, req_ch.slot[cgvr_pkg::VC_W-1:0]};
      ofs_raddr = {bank_ff, req_ch.slot[cgvr_pkg::VC_W-1:0]};
      ofs_wdata = req_ch.item_value;
      dst_waddr = {bank_ff, req_ch.slot[cgvr_pkg::EDGE_AW-2:0]};
      dst_raddr = {bank_ff, req_ch.slot[cgvr_pkg::EDGE_AW-2:0]};
      dst_wdata = req_ch.item_value;
      wgt_wdata = req_ch.edge_weight;
      ord_waddr = req_ch.slot[cgvr_pkg::VID_W-1:0];
      ord_raddr = idx_ff[cgvr_pkg::VID_W-1:0];
      ord_wdata = req_ch.item_value;
      inv_waddr = old_ff;
      inv_raddr = dst_rdata_ff[cgvr_pkg::VID_W-1:0];
      inv_wdata = idx_ff[cgvr_pkg::VID_W-1:0];
      seen_waddr = idx_ff[cgvr_pkg::VID_W-1:0];
      seen_raddr = ord_rdata_ff[cgvr_pkg::VID_W-1:0];
      seen_wdata = 1'b0;

      case (state_ff)
         cgvr_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_value_in  = '0;
               rsp_weight_in = '0;
               rsp_status_in = cgvr_pkg::STS_SLOT_RANGE;
               case (req_ch.command)
                  cgvr_pkg::CMD_LOAD_OFS: begin
                     if (req_ch.slot > cgvr_pkg::MAX_VERTICES) rsp_valid_in = 1'b1;
                     else ofs_we = 1'b1;
                  end
                  cgvr_pkg::CMD_LOAD_EDGE: begin
                     if (req_ch.slot >= cgvr_pkg::MAX_EDGES) rsp_valid_in = 1'b1;
                     else dst_we = 1'b1;
                  end
                  cgvr_pkg::CMD_LOAD_ORD: begin
                     if (req_ch.slot >= cgvr_pkg::MAX_VERTICES) rsp_valid_in = 1'b1;
                     else ord_we = 1'b1;
                  end
                  cgvr_pkg::CMD_RUN: begin
                     idx_in = '0;
                     rsp_valid_in = run_bad;
                  end
                  cgvr_pkg::CMD_READ_OFS: begin
                     rd_edge_in   = 1'b0;
                     rsp_valid_in = rd_ofs_bad;
                  end
                  cgvr_pkg::CMD_READ_EDGE: begin
                     rd_edge_in   = 1'b1;
                     rsp_valid_in = rd_edge_bad;
                  end
                  default: rsp_valid_in = 1'b0;
               endcase
            end
         end
         // read data back from the active bank
         cgvr_pkg::ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            if (rd_edge_ff) begin
               rsp_status_in = wp_ff ? cgvr_pkg::STS_OK : cgvr_pkg::STS_NO_WEIGHTS;
               rsp_value_in  = dst_rdata_ff;
               rsp_weight_in = wp_ff ? wgt_rdata_ff : '0;
            end else begin
               rsp_status_in = cgvr_pkg::STS_OK;
               rsp_value_in  = ofs_rdata_ff;
               rsp_weight_in = '0;
            end
         end
         // offset checks
         cgvr_pkg::ST_OFS_RD: ofs_raddr = {bank_ff, idx_ff[cgvr_pkg::VC_W-1:0]};
         cgvr_pkg::ST_OFS_CMP: begin
            prev_in = ofs_rdata_ff;
            idx_in  = idx_is_vc ? '0 : idx_ff + 1'b1;
            if (ofs_fail_first || ofs_fail_dec || ofs_fail_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ofs_fail_first ? cgvr_pkg::STS_FIRST_OFS :
                               ofs_fail_dec   ? cgvr_pkg::STS_OFS_DEC : cgvr_pkg::STS_LAST_OFS;
            end
         end
         // destination range checks
         cgvr_pkg::ST_DST_RD: begin
            dst_raddr = {bank_ff, idx_ff[cgvr_pkg::EDGE_AW-2:0]};
            if (idx_ff == ec_ff) idx_in = '0;
         end
         cgvr_pkg::ST_DST_CMP: begin
            idx_in = idx_ff + 1'b1;
            if (dst_bad) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cgvr_pkg::STS_BAD_DST;
            end
         end
         // clearing pass over the seen bits
         cgvr_pkg::ST_CLR: begin
            seen_we = 1'b1;
            idx_in  = (idx_ff[cgvr_pkg::VID_W-1:0] == '1) ? '0 : idx_ff + 1'b1;
         end
         // order checks
         cgvr_pkg::ST_ORD_RD: begin
            if (idx_is_vc) begin
               idx_in    = '0;
               pos_in    = '0;
               ofs_we    = 1'b1;
               ofs_waddr = {~bank_ff, {cgvr_pkg::VC_W{1'b0}}};
               ofs_wdata = '0;
            end
         end
         cgvr_pkg::ST_ORD_CHK: begin
            old_in = ord_rdata_ff[cgvr_pkg::VID_W-1:0];
            if (ord_bad) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cgvr_pkg::STS_ORD_RANGE;
            end
         end
         cgvr_pkg::ST_ORD_SEEN: begin
            if (seen_rdata_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cgvr_pkg::STS_ORD_DUP;
            end else begin
               seen_we    = 1'b1;
               seen_waddr = old_ff;
               seen_wdata = 1'b1;
               inv_we     = 1'b1;
               idx_in     = idx_ff + 1'b1;
            end
         end
         // rebuild into the idle bank
         cgvr_pkg::ST_RB_ORD_RD: begin
            if (idx_is_vc) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cgvr_pkg::STS_OK;
               bank_in       = ~bank_ff;
            end
         end
         cgvr_pkg::ST_RB_ORD: begin
            old_in    = ord_rdata_ff[cgvr_pkg::VID_W-1:0];
            ofs_raddr = {bank_ff, 1'b0, ord_rdata_ff[cgvr_pkg::VID_W-1:0]};
         end
         cgvr_pkg::ST_RB_BEG: begin
            e_in      = ofs_rdata_ff;
            ofs_raddr = {bank_ff, {1'b0, old_ff} + 11'd1};
         end
         cgvr_pkg::ST_RB_END: end_in = ofs_rdata_ff;
         cgvr_pkg::ST_RB_EDGE: begin
            dst_raddr = {bank_ff, e_ff[cgvr_pkg::EDGE_AW-2:0]};
            if (!edge_more) begin
               ofs_we    = 1'b1;
               ofs_waddr = {~bank_ff, idx_ff[cgvr_pkg::VC_W-1:0] + 11'd1};
               ofs_wdata = pos_ff;
               idx_in    = idx_ff + 1'b1;
            end
         end
         cgvr_pkg::ST_RB_INV: whold_in = wp_ff ? wgt_rdata_ff : '0;
         cgvr_pkg::ST_RB_WR: begin
            dst_we    = 1'b1;
            dst_waddr = {~bank_ff, pos_ff[cgvr_pkg::EDGE_AW-2:0]};
            dst_wdata = {3'b000, inv_rdata_ff};
            wgt_wdata = whold_ff;
            pos_in    = pos_ff + 1'b1;
            e_in      = e_ff + 1'b1;
         end
         default: rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cgvr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bank_ff      <= 1'b0;
         vc_ff        <= '0;
         ec_ff        <= '0;
         wp_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bank_ff      <= bank_in;
         if (csr_ch.valid) begin
            case (csr_ch.reg_index)
               cgvr_pkg::CSR_VERTEX_COUNT:    vc_ff <= csr_ch.wr_data[cgvr_pkg::VC_W-1:0];
               cgvr_pkg::CSR_EDGE_COUNT:      ec_ff <= csr_ch.wr_data;
               cgvr_pkg::CSR_WEIGHTS_PRESENT: wp_ff <= csr_ch.wr_data[0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      prev_ff       <= prev_in;
      old_ff        <= old_in;
      e_ff          <= e_in;
      end_ff        <= end_in;
      pos_ff        <= pos_in;
      whold_ff      <= whold_in;
      rd_edge_ff    <= rd_edge_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_weight_ff <= rsp_weight_in;
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (ofs_we) ofs_mem[ofs_waddr] <= ofs_wdata;
      ofs_rdata_ff <= ofs_mem[ofs_raddr];
   end

   always_ff @(posedge clock) begin
      if (dst_we) begin
         dst_mem[dst_waddr] <= dst_wdata;
         wgt_mem[dst_waddr] <= wgt_wdata;
      end
      dst_rdata_ff <= dst_mem[dst_raddr];
      wgt_rdata_ff <= wgt_mem[dst_raddr];
   end

   always_ff @(posedge clock) begin
      if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
      ord_rdata_ff <= ord_mem[ord_raddr];
   end

   always_ff @(posedge clock) begin
      if (inv_we) inv_mem[inv_waddr] <= inv_wdata;
      inv_rdata_ff <= inv_mem[inv_raddr];
   end

   always_ff @(posedge clock) begin
      if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
      seen_rdata_ff <= seen_mem[seen_raddr];
   end
endmodule
`default_nettype wire

// ----- rtl/cgvr_checker.sv -----
// port-level checks for the vertex reorder block, bound to the top level
// depends on cgvr_pkg and the macro header
`default_nettype none
`include "csr_graph_check_and_vertex_reorder_macros.svh"
module cgvr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [cgvr_pkg::STS_W-1:0] rsp_status,
   input wire logic [cgvr_pkg::WGT_W-1:0] rsp_weight
);
   // a waiting response holds until its transfer
   `CGVR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // no request is taken while a response waits
   `CGVR_ASSERT_NOW(a_one_in_flight, req_ready, !rsp_valid)
   // status stays within the defined codes
   `CGVR_ASSERT_NOW(a_status_range, rsp_valid, rsp_status <= cgvr_pkg::STS_NO_WEIGHTS)
   // a weight is only returned with an ok status
   `CGVR_ASSERT_NOW(a_weight_ok, rsp_valid && (rsp_status != cgvr_pkg::STS_OK), rsp_weight == '0)
endmodule

bind csr_graph_check_and_vertex_reorder cgvr_checker u_cgvr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_weight (rsp_ch.read_weight)
);
`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking bench for csr_graph_check_and_vertex_reorder: builds small csr graphs,
// loads them with optional faults, runs the check and reorder, reads back and compares each response
// depends on cgvr_pkg, cgvr_channels and the block itself
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV = 1024;
   localparam int NE = 4096;
   localparam int IDLE_LIMIT = 60000;
   localparam int SETTLE = 12;

   // command codes the block ignores
   localparam logic [cgvr_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [cgvr_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [cgvr_pkg::CMD_W-1:0]  command;
      logic [cgvr_pkg::SLOT_W-1:0] slot;
      logic [cgvr_pkg::VAL_W-1:0]  item_value;
      logic [cgvr_pkg::WGT_W-1:0]  edge_weight;
   } graph_cmd_type;

   typedef struct packed {
      logic [cgvr_pkg::STS_W-1:0] status;
      logic [cgvr_pkg::VAL_W-1:0] read_value;
      logic [cgvr_pkg::WGT_W-1:0] read_weight;
   } graph_rsp_type;

   logic clock;
   logic reset;

   cgvr_req_if req_ch ();
   cgvr_rsp_if rsp_ch ();
   cgvr_csr_if csr_ch ();

   csr_graph_check_and_vertex_reorder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // graph image as the block should hold it, two banks
   logic [cgvr_pkg::VAL_W-1:0] ofs_mem [2][0:NV];
   logic [cgvr_pkg::VAL_W-1:0] dst_mem [2][0:NE-1];
   logic [cgvr_pkg::WGT_W-1:0] wgt_mem [2][0:NE-1];
   logic [cgvr_pkg::VAL_W-1:0] ord_mem [0:NV-1];
   logic [cgvr_pkg::VID_W-1:0] inv_mem [0:NV-1];
   bit               seen    [0:NV-1];
   bit               ofs_wr  [2][0:NV];
   bit               dst_wr  [2][0:NE-1];
   bit               ord_wr  [0:NV-1];
   int               bank;
   int               vcount;
   int               ecount;
   bit               wpresent;

   graph_cmd_type cmd_backlog [$];
   graph_rsp_type graph_replies [$];

   int  errors;
   int  items_sent;
   int  rsp_seen;
   int  runs_ok;
   int  runs_failed;
   int  idle_cycles;
   bit  req_taken;

   // check the graph and order, rebuild into the idle bank on success
   function automatic logic [cgvr_pkg::STS_W-1:0] check_and_reorder();
      int a, b, pos, old, e, stop;
      if (vcount > NV || ecount > NE) return cgvr_pkg::STS_SLOT_RANGE;
      a = bank;
      if (ofs_mem[a][0] != 0) return cgvr_pkg::STS_FIRST_OFS;
      for (int i = 1; i <= vcount; i++)
         if (ofs_mem[a][i] < ofs_mem[a][i-1]) return cgvr_pkg::STS_OFS_DEC;
      if (ofs_mem[a][vcount] != ecount) return cgvr_pkg::STS_LAST_OFS;
      for (int i = 0; i < ecount; i++)
         if (dst_mem[a][i] >= vcount) return cgvr_pkg::STS_BAD_DST;
      for (int i = 0; i < NV; i++) seen[i] = 0;
      for (int n = 0; n < vcount; n++) begin
         if (ord_mem[n] >= vcount) return cgvr_pkg::STS_ORD_RANGE;
         if (seen[ord_mem[n]]) return cgvr_pkg::STS_ORD_DUP;
         seen[ord_mem[n]] = 1;
      end
      for (int n = 0; n < vcount; n++) inv_mem[ord_mem[n]] = n[cgvr_pkg::VID_W-1:0];
      b = a ^ 1;
      pos = 0;
      ofs_mem[b][0] = '0;
      ofs_wr[b][0] = 1;
      for (int n = 0; n < vcount; n++) begin
         old = ord_mem[n];
         e = ofs_mem[a][old];
         stop = ofs_mem[a][old+1];
         for (; e < stop && pos < NE; e++, pos++) begin
            dst_mem[b][pos] = cgvr_pkg::VAL_W'(inv_mem[dst_mem[a][e]]);
            wgt_mem[b][pos] = wpresent ? wgt_mem[a][e] : '0;
            dst_wr[b][pos] = 1;
         end
         ofs_mem[b][n+1] = pos[cgvr_pkg::VAL_W-1:0];
         ofs_wr[b][n+1] = 1;
      end
      bank = b;
      return cgvr_pkg::STS_OK;
   endfunction

   // update the graph image for one command and queue its response, if it has one
   function automatic void graph_predict(graph_cmd_type c);
      graph_rsp_type r;
      bit         has;
      r = '0;
      has = 0;
      case (c.command)
         cgvr_pkg::CMD_LOAD_OFS: begin
            if (c.slot > cgvr_pkg::MAX_VERTICES) begin
               has = 1;
               r.status = cgvr_pkg::STS_SLOT_RANGE;
            end else begin
               ofs_mem[bank][c.slot] = c.item_value;
               ofs_wr[bank][c.slot] = 1;
            end
         end
         cgvr_pkg::CMD_LOAD_EDGE: begin
            if (c.slot >= cgvr_pkg::MAX_EDGES) begin
               has = 1;
               r.status = cgvr_pkg::STS_SLOT_RANGE;
            end else begin
               dst_mem[bank][c.slot] = c.item_value;
               wgt_mem[bank][c.slot] = c.edge_weight;
               dst_wr[bank][c.slot] = 1;
            end
         end
         cgvr_pkg::CMD_LOAD_ORD: begin
            if (c.slot >= cgvr_pkg::MAX_VERTICES) begin
               has = 1;
               r.status = cgvr_pkg::STS_SLOT_RANGE;
            end else begin
               ord_mem[c.slot] = c.item_value;
               ord_wr[c.slot] = 1;
            end
         end
         cgvr_pkg::CMD_RUN: begin
            has = 1;
            r.status = check_and_reorder();
            if (r.status == cgvr_pkg::STS_OK) runs_ok++;
            else runs_failed++;
         end
         cgvr_pkg::CMD_READ_OFS: begin
            has = 1;
            if (c.slot > vcount || c.slot > cgvr_pkg::MAX_VERTICES)
               r.status = cgvr_pkg::STS_SLOT_RANGE;
            else r.read_value = ofs_mem[bank][c.slot];
         end
         cgvr_pkg::CMD_READ_EDGE: begin
            has = 1;
            if (c.slot >= ecount || c.slot >= cgvr_pkg::MAX_EDGES) begin
               r.status = cgvr_pkg::STS_SLOT_RANGE;
            end else begin
               r.read_value = dst_mem[bank][c.slot];
               if (wpresent) r.read_weight = wgt_mem[bank][c.slot];
               else r.status = cgvr_pkg::STS_NO_WEIGHTS;
            end
         end
         default: ;
      endcase
      if (has) graph_replies.insert(graph_replies.size(), r);
   endfunction

   // a run touches offsets 0..V and edges 0..E-1 of the active bank, and order 0..V-1
   function automatic bit run_is_safe();
      if (vcount > NV || ecount > NE) return 1;
      for (int i = 0; i <= vcount; i++) if (!ofs_wr[bank][i]) return 0;
      for (int i = 0; i < ecount; i++) if (!dst_wr[bank][i]) return 0;
      for (int i = 0; i < vcount; i++) if (!ord_wr[i]) return 0;
      return 1;
   endfunction

   task automatic issue(input logic [cgvr_pkg::CMD_W-1:0] cmd, input int slot, input int val,
                        input logic [cgvr_pkg::WGT_W-1:0] wgt);
      graph_cmd_type c;
      c.command = cmd;
      c.slot = slot[cgvr_pkg::SLOT_W-1:0];
      c.item_value = val[cgvr_pkg::VAL_W-1:0];
      c.edge_weight = wgt;
      if (cmd == cgvr_pkg::CMD_RUN && !run_is_safe()) return;
      if (cmd == cgvr_pkg::CMD_READ_OFS && slot <= vcount && slot <= NV &&
          !ofs_wr[bank][slot]) return;
      if (cmd == cgvr_pkg::CMD_READ_EDGE && slot < ecount && slot < NE &&
          !dst_wr[bank][slot]) return;
      graph_predict(c);
      cmd_backlog.insert(cmd_backlog.size(), c);
      if (cmd <= cgvr_pkg::CMD_READ_EDGE) items_sent++;
   endtask

   // random filler: range errors, unused codes and reads of loaded entries
   task automatic maybe_noise();
      if ($urandom_range(9) != 0) return;
      case ($urandom_range(5))
         0: issue(cgvr_pkg::CMD_LOAD_OFS, $urandom_range(8191, NV + 1), $urandom, $urandom);
         1: issue(cgvr_pkg::CMD_LOAD_EDGE, $urandom_range(8191, NE), $urandom, $urandom);
         2: issue(cgvr_pkg::CMD_LOAD_ORD, $urandom_range(8191, NV), $urandom, $urandom);
         3: issue(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), $urandom, $urandom,
                  $urandom);
         4: issue(cgvr_pkg::CMD_READ_OFS, $urandom_range(vcount + 2), 0, $urandom);
         default: issue(cgvr_pkg::CMD_READ_EDGE, $urandom_range(ecount + 1), 0, $urandom);
      endcase
   endtask

   task automatic wait_idle();
      while (cmd_backlog.size() != 0 || req_ch.valid || graph_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [cgvr_pkg::CSR_IDX_W-1:0] idx, input int data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data <= data[cgvr_pkg::CSR_DAT_W-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         cgvr_pkg::CSR_VERTEX_COUNT: vcount = data & 'h7FF;
         cgvr_pkg::CSR_EDGE_COUNT:   ecount = data & 'h1FFF;
         default:                    wpresent = data[0];
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_graph_size(input int nv, input int ne, input int wp);
      wait_idle();
      write_csr(cgvr_pkg::CSR_VERTEX_COUNT, nv);
      write_csr(cgvr_pkg::CSR_EDGE_COUNT, ne);
      write_csr(cgvr_pkg::CSR_WEIGHTS_PRESENT, wp);
   endtask

   // load one graph with an optional fault, run it and read it back
   task automatic graph_phase(input int nv, input int ne, input int fault, input bit twice);
      int ofs_l [0:NV];
      int dst_l [0:NE-1];
      int ord_l [0:NV-1];
      int j, k, t;
      ofs_l[0] = 0;
      for (int i = 1; i <= nv; i++)
         ofs_l[i] = (i == nv) ? ne : $urandom_range(ofs_l[i-1], (ofs_l[i-1] + 4 < ne) ?
                                                     ofs_l[i-1] + 4 : ne);
      for (int i = 0; i < ne; i++) dst_l[i] = (nv > 0) ? $urandom_range(nv - 1) : 0;
      for (int i = 0; i < nv; i++) ord_l[i] = i;
      for (int i = nv - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = ord_l[i]; ord_l[i] = ord_l[j]; ord_l[j] = t;
      end
      // inject the requested fault
      case (fault)
         1: ofs_l[0] = $urandom_range(8191, 1);
         2: if (nv >= 2) begin
               k = $urandom_range(nv, 2);
               ofs_l[k-1] = ofs_l[k] + $urandom_range(9, 1);
            end
         3: ofs_l[nv] = ne + $urandom_range(6, 1);
         4: if (ne > 0) dst_l[$urandom_range(ne - 1)] = $urandom_range(8191, nv);
         5: if (nv > 0) ord_l[$urandom_range(nv - 1)] = $urandom_range(8191, nv);
         6: if (nv >= 2) ord_l[0] = ord_l[$urandom_range(nv - 1, 1)];
         default: ;
      endcase
      for (int i = 0; i <= nv; i++) begin
         issue(cgvr_pkg::CMD_LOAD_OFS, i, ofs_l[i], $urandom);
         maybe_noise();
      end
      for (int i = 0; i < ne; i++) begin
         t = $urandom_range(3);
         issue(cgvr_pkg::CMD_LOAD_EDGE, i, dst_l[i],
               (t == 0) ? 32'h0 : (t == 1) ? 32'hFFFF_FFFF : $urandom);
         maybe_noise();
      end
      for (int i = 0; i < nv; i++) begin
         issue(cgvr_pkg::CMD_LOAD_ORD, i, ord_l[i], $urandom);
         maybe_noise();
      end
      issue(cgvr_pkg::CMD_RUN, $urandom, $urandom, $urandom);
      if (twice) issue(cgvr_pkg::CMD_RUN, $urandom, $urandom, $urandom);
      for (int i = 0; i <= nv + 1 && i < 40; i++)
         issue(cgvr_pkg::CMD_READ_OFS, i, 0, $urandom);
      for (int i = 0; i <= ne && i < 60; i++)
         issue(cgvr_pkg::CMD_READ_EDGE, i, 0, $urandom);
   endtask

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = '0;
      req_ch.slot = '0;
      req_ch.item_value = '0;
      req_ch.edge_weight = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.wr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // sender: bursts from the backlog with random gaps
   int req_burst = 4;
   int req_gap = 0;
   always @(negedge clock) begin
      graph_cmd_type c;
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (cmd_backlog.size() > 0) begin
            c = cmd_backlog.pop_front();
            req_ch.command <= c.command;
            req_ch.slot <= c.slot;
            req_ch.item_value <= c.item_value;
            req_ch.edge_weight <= c.edge_weight;
            req_ch.valid <= 1'b1;
            req_burst--;
            if (req_burst <= 0) begin
               req_burst = $urandom_range(24, 1);
               req_gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern that changes mode, plus one long hold-off
   int rx_cycle = 0;
   int rx_hold = 0;
   bit rx_held = 0;
   always @(negedge clock) begin
      if (!reset) begin
         rx_cycle++;
         if (!rx_held && rsp_seen >= 50) begin
            rx_held = 1;
            rx_hold = 600;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 256) % 4)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= (rx_cycle % 5) != 0;
               2: rsp_ch.ready <= $urandom_range(9) < 6;
               default: rsp_ch.ready <= (rx_cycle % 13) < 9;
            endcase
         end
      end
   end

   // monitor: response compare and watchdog
   always @(posedge clock) begin
      graph_rsp_type want;
      req_taken = req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_taken || (rsp_ch.valid && rsp_ch.ready) || (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (graph_replies.size() == 0) begin
               errors++;
               $display("%0t: response with none expected: status %0d value %0d weight %h",
                        $time, rsp_ch.status, rsp_ch.read_value, rsp_ch.read_weight);
            end else begin
               want = graph_replies.pop_front();
               if (rsp_ch.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_ch.status);
               end
               if (rsp_ch.read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read_value expected %0d actual %0d", $time,
                           want.read_value, rsp_ch.read_value);
               end
               if (rsp_ch.read_weight !== want.read_weight) begin
                  errors++;
                  $display("%0t: read_weight expected %h actual %h", $time,
                           want.read_weight, rsp_ch.read_weight);
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int nv, ne, f;
      errors = 0; items_sent = 0; rsp_seen = 0; runs_ok = 0; runs_failed = 0;
      idle_cycles = 0; bank = 0; vcount = 0; ecount = 0; wpresent = 0;
      @(negedge reset);
      repeat (2) @(posedge clock);

      // directed: empty graph, range errors, unused codes, field extremes
      set_graph_size(0, 0, 0);
      issue(CMD_SPARE_LO, 8191, 8191, 32'hFFFF_FFFF);
      issue(CMD_SPARE_HI, 0, 0, 0);
      issue(cgvr_pkg::CMD_LOAD_OFS, 8191, 0, 0);
      issue(cgvr_pkg::CMD_LOAD_OFS, NV + 1, 0, 0);
      issue(cgvr_pkg::CMD_LOAD_EDGE, NE, 1, 1);
      issue(cgvr_pkg::CMD_LOAD_EDGE, 8191, 8191, 32'hFFFF_FFFF);
      issue(cgvr_pkg::CMD_LOAD_ORD, NV, 0, 0);
      issue(cgvr_pkg::CMD_LOAD_ORD, 8191, 8191, 0);
      issue(cgvr_pkg::CMD_READ_OFS, 1, 0, 0);
      issue(cgvr_pkg::CMD_READ_OFS, 8191, 0, 0);
      issue(cgvr_pkg::CMD_READ_EDGE, 0, 0, 0);
      issue(cgvr_pkg::CMD_READ_EDGE, 8191, 0, 0);
      issue(cgvr_pkg::CMD_LOAD_OFS, 0, 0, 0);
      issue(cgvr_pkg::CMD_READ_OFS, 0, 0, 0);
      issue(cgvr_pkg::CMD_RUN, 0, 0, 0);
      issue(cgvr_pkg::CMD_READ_OFS, 0, 0, 0);
      issue(cgvr_pkg::CMD_LOAD_OFS, NV, 8191, 0);
      issue(cgvr_pkg::CMD_LOAD_EDGE, NE - 1, 8191, 32'hFFFF_FFFF);
      issue(cgvr_pkg::CMD_LOAD_ORD, NV - 1, 8191, 0);
      set_graph_size(1, 1, 1);
      graph_phase(1, 1, 0, 0);
      set_graph_size(1, 1, 0);
      issue(cgvr_pkg::CMD_READ_EDGE, 0, 0, 0);
      // oversized register values, and the largest vertex count
      set_graph_size(2047, 8191, 1);
      issue(cgvr_pkg::CMD_RUN, 0, 0, 0);
      issue(cgvr_pkg::CMD_READ_OFS, NV + 1, 0, 0);
      issue(cgvr_pkg::CMD_READ_EDGE, NE, 0, 0);
      set_graph_size(NV, 8, 1);
      issue(cgvr_pkg::CMD_LOAD_OFS, NV, 4095, 0);
      issue(cgvr_pkg::CMD_READ_OFS, NV, 0, 0);
      issue(cgvr_pkg::CMD_READ_OFS, NV + 1, 0, 0);
      set_graph_size(3, NE, 0);
      issue(cgvr_pkg::CMD_RUN, 0, 0, 0);

      // random graphs, about half clean, the rest with at most one fault each
      while (items_sent < 1200) begin
         nv = $urandom_range(12);
         ne = (nv == 0) ? 0 : $urandom_range(24);
         f = ($urandom_range(1) == 0) ? 0 : $urandom_range(6, 1);
         set_graph_size(nv, ne, $urandom_range(1));
         graph_phase(nv, ne, f, $urandom_range(3) == 0);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d commands, %0d responses, %0d clean runs and %0d rejected runs",
               items_sent, rsp_seen, runs_ok, runs_failed);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/cgvr_pkg.sv
rtl/cgvr_channels.sv
rtl/csr_graph_check_and_vertex_reorder.sv
rtl/cgvr_checker.sv
verif/testbench.sv
